FILE: hw/rtl/spbs_pkg.sv
// spbs_pkg: shared types and constants for the spectral peak bin sieve
// no dependencies; imported by every module of the block

package spbs_pkg;

    localparam int LEN_W      = 7;
    localparam int NYQ_W      = 23;
    localparam int SCALE_W    = 32;
    localparam int DATA_W     = 24;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = NYQ_W + SCALE_W;
    localparam int BIN_SHIFT  = 40;
    localparam int BIN_W      = PROD_W - BIN_SHIFT;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NYQUIST_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_PER_HZ      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REMAINDER_ENABLE = 2'd3;

    localparam logic [LEN_W-1:0]   RST_FRAME_LENGTH     = 7'd64;
    localparam logic [NYQ_W-1:0]   RST_NYQUIST_LIMIT    = 23'd5644800;
    localparam logic [SCALE_W-1:0] RST_BINS_PER_HZ      = 32'd6233905;
    localparam logic               RST_REMAINDER_ENABLE = 1'b0;

    typedef struct packed {
        logic        [DATA_W-1:0] magnitude;
        logic signed [DATA_W-1:0] frequency;
    } t_in_word;

    typedef struct packed {
        logic        [DATA_W-1:0] bin_magnitude;
        logic signed [DATA_W-1:0] bin_frequency;
        logic        [DATA_W-1:0] unused_magnitude;
        logic signed [DATA_W-1:0] unused_frequency;
        logic                     last_of_frame;
    } t_out_word;

    typedef struct packed {
        logic [LEN_W-1:0]   frame_length;
        logic [NYQ_W-1:0]   nyquist_limit;
        logic [SCALE_W-1:0] bins_per_hz;
        logic               remainder_enable;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic index;
        logic update;
        logic claim;
        logic emit;
        logic cnt_clr;
        logic frame_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic ends_frame;
        logic claim_last;
        logic emit_last;
    } t_dp_sts;

endpackage

FILE: hw/rtl/spbs_ctrl.sv
// spbs_ctrl: sequencing state machine for the spectral peak bin sieve
// depends on spbs_pkg; drives the datapath through t_dp_cmd, reads t_dp_sts

module spbs_ctrl
    import spbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_IDX,
        S_UPD,
        S_CLAIM,
        S_CDRAIN,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign busy     = !((r_state == S_IDLE) || ((r_state == S_UPD) && !i_sts.ends_frame));
    assign w_accept = start && !busy;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.accept    = w_accept;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_IDX;
            end
            S_IDX: begin
                o_cmd.index = 1'b1;
                n_state     = S_UPD;
            end
            S_UPD: begin
                o_cmd.update  = 1'b1;
                o_cmd.cnt_clr = 1'b1;
                if (i_sts.ends_frame) begin
                    n_state = S_CLAIM;
                end else if (w_accept) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CLAIM: begin
                o_cmd.claim = 1'b1;
                if (i_sts.claim_last) begin
                    n_state = S_CDRAIN;
                end
            end
            S_CDRAIN: begin
                o_cmd.cnt_clr = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.emit_last) begin
                    o_cmd.frame_clr = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/spbs_datapath.sv
// spbs_datapath: bin mapping, bin and sample stores, claim sweep and result stage
// depends on spbs_pkg; commanded by spbs_ctrl

module spbs_datapath
    import spbs_pkg::*;
#(
    parameter int FRAME_SIZE = 64
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    input  t_in_word  i_item,
    output logic      o_strobe,
    output t_out_word o_result
);

    localparam int AW = $clog2(FRAME_SIZE);
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(FRAME_SIZE);
    localparam logic [AW-1:0]    LAST_IDX = AW'(FRAME_SIZE - 1);

    // stores
    logic [DATA_W-1:0] r_bmag_mem  [FRAME_SIZE];
    logic [DATA_W-1:0] r_bfreq_mem [FRAME_SIZE];
    logic [AW-1:0]     r_src_mem   [FRAME_SIZE];
    logic [DATA_W-1:0] r_imag_mem  [FRAME_SIZE];
    logic [DATA_W-1:0] r_ifreq_mem [FRAME_SIZE];

    logic [FRAME_SIZE-1:0] r_taken;
    logic [FRAME_SIZE-1:0] r_claimed;

    // item registers
    logic [DATA_W-1:0] r_mag;
    logic [DATA_W-1:0] r_freq;
    logic [AW-1:0]     r_pos;
    logic              r_ends;
    logic [AW-1:0]     r_pos_cnt;
    logic [PROD_W-1:0] r_prod;
    logic [AW-1:0]     r_bin;
    logic              r_hit;
    logic [AW-1:0]     r_cnt;

    // read data
    logic [DATA_W-1:0] r_rd_bmag;
    logic [DATA_W-1:0] r_rd_bfreq;
    logic [DATA_W-1:0] r_rd_imag;
    logic [DATA_W-1:0] r_rd_ifreq;
    logic [AW-1:0]     r_rd_src;

    // sweep and result stages
    logic r_cv;
    logic r_ev;
    logic r_et;
    logic r_ec;
    logic r_el;
    logic r_strobe;
    t_out_word r_out;

    logic [LEN_W-1:0] w_len;
    logic             w_ends_now;
    logic [BIN_W-1:0] w_bin_full;
    logic             w_over;
    logic             w_hit;
    logic [AW-1:0]    w_rd_addr;
    logic             w_win;

    always_comb begin
        if (i_cfg.frame_length == '0) begin
            w_len = LEN_W'(1);
        end else if (i_cfg.frame_length > MAX_LEN) begin
            w_len = MAX_LEN;
        end else begin
            w_len = i_cfg.frame_length;
        end
    end

    assign w_ends_now = (LEN_W'(r_pos_cnt) + LEN_W'(1)) >= w_len;

    // bin mapping from the registered product
    assign w_bin_full = r_freq[DATA_W-1] ? '0 : r_prod[PROD_W-1:BIN_SHIFT];
    assign w_over     = !r_freq[DATA_W-1] && (r_freq[NYQ_W-1:0] > i_cfg.nyquist_limit);
    assign w_hit      = (r_freq != '0) && !w_over && (w_bin_full < BIN_W'(w_len));
    assign w_rd_addr  = i_cmd.emit ? r_cnt : w_bin_full[AW-1:0];
    assign w_win      = r_hit && (!r_taken[r_bin] || (r_mag >= r_rd_bmag));

    assign o_sts.ends_frame = r_ends;
    assign o_sts.claim_last = (r_cnt == LAST_IDX);
    assign o_sts.emit_last  = (LEN_W'(r_cnt) + LEN_W'(1)) >= w_len;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mag                 <= i_item.magnitude;
            r_freq                <= i_item.frequency;
            r_pos                 <= r_pos_cnt;
            r_ends                <= w_ends_now;
            r_imag_mem[r_pos_cnt] <= i_item.magnitude;
            r_ifreq_mem[r_pos_cnt] <= i_item.frequency;
        end
        r_prod <= PROD_W'(r_freq[NYQ_W-1:0]) * PROD_W'(i_cfg.bins_per_hz);
        if (i_cmd.index) begin
            r_bin <= w_bin_full[AW-1:0];
            r_hit <= w_hit;
        end
        if (i_cmd.update && w_win) begin
            r_bmag_mem[r_bin]  <= r_mag;
            r_bfreq_mem[r_bin] <= r_freq;
            r_src_mem[r_bin]   <= r_pos;
        end
        r_rd_bmag  <= r_bmag_mem[w_rd_addr];
        r_rd_bfreq <= r_bfreq_mem[w_rd_addr];
        r_rd_imag  <= r_imag_mem[r_cnt];
        r_rd_ifreq <= r_ifreq_mem[r_cnt];
        r_rd_src   <= r_src_mem[r_cnt];
        r_et       <= r_taken[r_cnt];
        r_ec       <= r_claimed[r_cnt];
        r_el       <= o_sts.emit_last;
        if (r_ev) begin
            r_out.bin_magnitude    <= r_et ? r_rd_bmag : '0;
            r_out.bin_frequency    <= r_et ? r_rd_bfreq : '0;
            r_out.unused_magnitude <= (i_cfg.remainder_enable && !r_ec) ? r_rd_imag : '0;
            r_out.unused_frequency <= (i_cfg.remainder_enable && !r_ec) ? r_rd_ifreq : '0;
            r_out.last_of_frame    <= r_el;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_cnt <= '0;
            r_cnt     <= '0;
            r_taken   <= '0;
            r_claimed <= '0;
            r_cv      <= 1'b0;
            r_ev      <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_pos_cnt <= w_ends_now ? '0 : r_pos_cnt + AW'(1);
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.claim || i_cmd.emit) begin
                r_cnt <= r_cnt + AW'(1);
            end
            r_cv     <= i_cmd.claim && r_taken[r_cnt];
            r_ev     <= i_cmd.emit;
            r_strobe <= r_ev;
            if (i_cmd.frame_clr) begin
                r_taken   <= '0;
                r_claimed <= '0;
            end else begin
                if (i_cmd.update && w_win) begin
                    r_taken[r_bin] <= 1'b1;
                end
                if (r_cv) begin
                    r_claimed[r_rd_src] <= 1'b1;
                end
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

FILE: hw/rtl/spectral_peak_bin_sieve.sv
// spectral_peak_bin_sieve: top level with configuration registers
// depends on spbs_pkg, spbs_ctrl and spbs_datapath
//
// One sample word is taken when start is high and busy is low. An ordinary
// sample passes through capture, a 23x32 bin multiply and a single-port bin
// store read and then write, and the next word can be taken during the
// write. The word that completes a frame is followed by a claim sweep over
// all FRAME_SIZE entries of the bin source store, a settling step and an
// emission pass over frame_length bins; busy stays high throughout. Results
// come out one per cycle on o_strobe, registered through r_ev and r_strobe
// behind the pass, and cannot be held off by the receiver; the final one
// carries last_of_frame.

module spectral_peak_bin_sieve
    import spbs_pkg::*;
#(
    parameter int FRAME_SIZE = 64
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_word              i_item,
    output logic                  o_strobe,
    output t_out_word             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_length     <= RST_FRAME_LENGTH;
            r_cfg.nyquist_limit    <= RST_NYQUIST_LIMIT;
            r_cfg.bins_per_hz      <= RST_BINS_PER_HZ;
            r_cfg.remainder_enable <= RST_REMAINDER_ENABLE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_LENGTH:     r_cfg.frame_length     <= i_cfg_data[LEN_W-1:0];
                CFG_NYQUIST_LIMIT:    r_cfg.nyquist_limit    <= i_cfg_data[NYQ_W-1:0];
                CFG_BINS_PER_HZ:      r_cfg.bins_per_hz      <= i_cfg_data[SCALE_W-1:0];
                CFG_REMAINDER_ENABLE: r_cfg.remainder_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    spbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    spbs_datapath #(
        .FRAME_SIZE (FRAME_SIZE)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

FILE: hw/rtl/spbs_checker.sv
// spbs_checker: port-level assertions for spectral_peak_bin_sieve
// depends on spbs_pkg; bound to the top level below

module spbs_checker
    import spbs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_strobe,
    input t_out_word o_result
);

    // an accepted word always occupies the block
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after an accepted word");

    // busy only rises on an accepted word
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    // every result belongs to an emission pass, during which busy was high
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy, 2))
        else $error("result word outside an emission pass");

    // nothing follows the last word of a frame directly
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_of_frame) |=> !o_strobe)
        else $error("result word directly after last of frame");

endmodule

bind spectral_peak_bin_sieve spbs_checker u_spbs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

FILE: dv/spbs_sieve_checker.sv
// spbs_sieve_checker: watches the sample, result and register ports of the sieve,
// keeps its own copy of the bins and compares every result word field by field
// depends on spbs_pkg

module spbs_sieve_checker
    import spbs_pkg::*;
#(
    parameter int FRAME_SIZE = 64
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_in_word              i_item,
    input  logic                  i_strobe,
    input  t_out_word             i_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending
);

    logic [LEN_W-1:0]   frame_len;
    logic [NYQ_W-1:0]   nyq_limit;
    logic [SCALE_W-1:0] hz_scale;
    logic               keep_rest;

    logic [DATA_W-1:0] peak_mag   [FRAME_SIZE];
    logic [DATA_W-1:0] peak_freq  [FRAME_SIZE];
    int                peak_src   [FRAME_SIZE];
    bit                peak_held  [FRAME_SIZE];
    logic [DATA_W-1:0] frame_mag  [FRAME_SIZE];
    logic [DATA_W-1:0] frame_freq [FRAME_SIZE];
    bit                claimed    [FRAME_SIZE];
    int                fill;
    int                mismatches;
    t_out_word         due;
    t_out_word         due_words[$];

    task automatic report(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
        if (got !== want)
            report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic clear_peaks();
        for (int k = 0; k < FRAME_SIZE; k++) begin
            peak_mag[k]  = '0;
            peak_freq[k] = '0;
            peak_held[k] = 1'b0;
            claimed[k]   = 1'b0;
        end
        fill = 0;
    endtask

    task automatic sieve_sample(input t_in_word w);
        int               span;
        int               pos;
        int               freq;
        int               bin;
        longint unsigned  prod;
        t_out_word        r;
        span = (frame_len == 0) ? 1 :
               ((frame_len > FRAME_SIZE) ? FRAME_SIZE : int'(frame_len));
        pos  = fill % FRAME_SIZE;
        freq = $signed(w.frequency);
        frame_mag[pos]  = w.magnitude;
        frame_freq[pos] = w.frequency;
        bin = span;
        if (freq < 0) begin
            bin = 0;
        end else if (freq > 0 && freq <= int'(nyq_limit)) begin
            prod = 64'(freq) * 64'(hz_scale);
            bin  = int'(prod >> BIN_SHIFT);
        end
        // later sample wins a tie
        if (bin < span && w.magnitude >= peak_mag[bin]) begin
            peak_mag[bin]  = w.magnitude;
            peak_freq[bin] = w.frequency;
            peak_src[bin]  = pos;
            peak_held[bin] = 1'b1;
        end
        fill = pos + 1;
        if (fill >= span) begin
            for (int k = 0; k < FRAME_SIZE; k++)
                if (peak_held[k])
                    claimed[peak_src[k] % FRAME_SIZE] = 1'b1;
            for (int k = 0; k < span; k++) begin
                r.bin_magnitude = peak_mag[k];
                r.bin_frequency = peak_freq[k];
                if (keep_rest && !claimed[k]) begin
                    r.unused_magnitude = frame_mag[k];
                    r.unused_frequency = frame_freq[k];
                end else begin
                    r.unused_magnitude = '0;
                    r.unused_frequency = '0;
                end
                r.last_of_frame = (k == span - 1);
                due_words.push_back(r);
            end
            clear_peaks();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_len  = RST_FRAME_LENGTH;
            nyq_limit  = RST_NYQUIST_LIMIT;
            hz_scale   = RST_BINS_PER_HZ;
            keep_rest  = RST_REMAINDER_ENABLE;
            mismatches = 0;
            due_words.delete();
            clear_peaks();
        end else begin
            if (i_strobe) begin
                if (due_words.size() == 0) begin
                    report($sformatf("result word with nothing due: %h", i_result));
                end else begin
                    due = due_words.pop_front();
                    check_field("bin_magnitude", i_result.bin_magnitude, due.bin_magnitude);
                    check_field("bin_frequency", i_result.bin_frequency, due.bin_frequency);
                    check_field("unused_magnitude", i_result.unused_magnitude,
                                due.unused_magnitude);
                    check_field("unused_frequency", i_result.unused_frequency,
                                due.unused_frequency);
                    check_field("last_of_frame", DATA_W'(i_result.last_of_frame),
                                DATA_W'(due.last_of_frame));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_LENGTH:     frame_len = i_cfg_data[LEN_W-1:0];
                    CFG_NYQUIST_LIMIT:    nyq_limit = i_cfg_data[NYQ_W-1:0];
                    CFG_BINS_PER_HZ:      hz_scale  = i_cfg_data[SCALE_W-1:0];
                    CFG_REMAINDER_ENABLE: keep_rest = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                sieve_sample(i_item);
        end
        o_mismatches <= mismatches;
        o_pending    <= due_words.size();
    end

endmodule

FILE: dv/spectral_peak_bin_sieve_tb.sv
// spectral_peak_bin_sieve_tb: drives sample words and register writes into the sieve
// through directed frames and randomised phases; the checker judges every result word
// depends on spbs_pkg, spectral_peak_bin_sieve and spbs_sieve_checker

module spectral_peak_bin_sieve_tb;
    import spbs_pkg::*;

    localparam int FRAME_SIZE  = 64;
    localparam int STALL_LIMIT = 3000;
    localparam int NYQ_MAX     = 8388607;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in_word              i_item;
    logic                  o_strobe;
    t_out_word             o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    mismatches;
    int                    pending;
    int                    quiet_cycles;

    spectral_peak_bin_sieve #(
        .FRAME_SIZE (FRAME_SIZE)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    spbs_sieve_checker #(
        .FRAME_SIZE (FRAME_SIZE)
    ) sieve_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_sample(input t_in_word w);
        start  <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // wait until every due word has come and the block is idle
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int len, input int nyq, input longint bph, input bit rem);
        settle();
        reg_write(CFG_FRAME_LENGTH, CFG_DATA_W'(len));
        reg_write(CFG_NYQUIST_LIMIT, CFG_DATA_W'(nyq));
        reg_write(CFG_BINS_PER_HZ, CFG_DATA_W'(bph));
        reg_write(CFG_REMAINDER_ENABLE, CFG_DATA_W'(rem));
    endtask

    task automatic run_phase(input int len, input int nyq, input longint bph, input bit rem,
                             input int count, input int idle_pct);
        int       span;
        int       kind;
        int       f;
        longint   reach;
        t_in_word w;
        configure(len, nyq, bph, rem);
        span = (len == 0) ? 1 : ((len > FRAME_SIZE) ? FRAME_SIZE : len);
        // highest frequency that still lands inside the frame
        reach = (bph == 0) ? NYQ_MAX : (((longint'(span)) << BIN_SHIFT) - 1) / bph;
        if (reach > nyq)
            reach = nyq;
        repeat (count) begin
            kind = $urandom_range(0, 99);
            if (kind < 60 && reach >= 1)
                f = $urandom_range(1, int'(reach));
            else if (kind < 70)
                f = -int'($urandom_range(1, 8388608));
            else if (kind < 75)
                f = 0;
            else if (kind < 85 && nyq < NYQ_MAX)
                f = $urandom_range(nyq + 1, NYQ_MAX);
            else
                f = $urandom();
            w.frequency = f[DATA_W-1:0];
            kind = $urandom_range(0, 99);
            if (kind < 40)
                w.magnitude = DATA_W'($urandom());
            else if (kind < 75)
                w.magnitude = DATA_W'($urandom_range(0, 7));
            else if (kind < 85)
                w.magnitude = '0;
            else if (kind < 92)
                w.magnitude = '1;
            else
                w.magnitude = DATA_W'($urandom_range(0, 255));
            send_sample(w);
            if ($urandom_range(0, 99) < idle_pct) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bin is frequency >> 12 here; words are {magnitude, frequency}
        configure(4, 5644800, 64'h1000_0000, 1'b1);
        send_sample({24'h000010, 24'h001000});
        send_sample({24'h000010, 24'h001fff});  // tie, later word wins
        send_sample({24'h000000, 24'h002000});  // zero magnitude takes an empty bin
        send_sample({24'hffffff, 24'hffffff});  // negative goes to bin zero
        send_sample({24'hffffff, 24'h000000});  // zero frequency ignored
        send_sample({24'h000005, 24'h800000});
        send_sample({24'h000003, 24'h7fffff});  // above nyquist
        send_sample({24'h000009, 24'h562200});  // at nyquist, bin beyond frame
        send_sample({24'h000007, 24'h003000});
        send_sample({24'h000008, 24'h003800});  // overtakes the previous winner
        send_sample({24'h000002, 24'h000100});
        send_sample({24'h000001, 24'h001000});
        send_sample({24'h000004, 24'h002000});
        send_sample({24'h000006, 24'h000800});
        send_sample({24'h00000a, 24'h003000});
        // shorter frame mid-way through
        configure(2, 5644800, 64'h1000_0000, 1'b1);
        send_sample({24'h0000ff, 24'h001000});
        configure(0, 5644800, 64'h1000_0000, 1'b1);
        send_sample({24'h123456, 24'h000400});

        run_phase(8,   5644800, 6233905,      1'b1, 60, 0);
        run_phase(64,  5644800, 6233905,      1'b1, 64, 58);
        run_phase(1,   0,       64'hffffffff, 1'b0, 20, 33);
        run_phase(127, NYQ_MAX, 64'hffffffff, 1'b1, 64, 0);
        run_phase(5,   NYQ_MAX, 0,            1'b1, 40, 58);
        run_phase(12,  2000000, 64'h1000_0000, 1'b0, 48, 33);
        run_phase(3,   5644800, 6233905,      1'b1, 30, 0);
        run_phase(0,   NYQ_MAX, 64'h4000_0000, 1'b1, 10, 58);
        run_phase(16,  1000,    64'hffffffff, 1'b1, 48, 0);
        run_phase(6,   5644800, 6233905,      1'b0, 36, 33);

        settle();
        repeat (140) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/spbs_pkg.sv
hw/rtl/spbs_ctrl.sv
hw/rtl/spbs_datapath.sv
hw/rtl/spectral_peak_bin_sieve.sv
hw/rtl/spbs_checker.sv
dv/spbs_sieve_checker.sv
dv/spectral_peak_bin_sieve_tb.sv
